FILE: design/shbin_pkg.sv
// ---------------------------------------------------------------------------
// shbin_pkg: shared types and constants for the spatial hash binning unit
// Hash primes, register indexes, controller commands and status.
// ---------------------------------------------------------------------------
package shbin_pkg;

   localparam int DEF_MAX_POINTS  = 65536;
   localparam int DEF_MAX_BUCKETS = 1048576;

   localparam logic [31:0] HASH_PX  = 32'd73856093;
   localparam logic [31:0] HASH_PY  = 32'd19349663;
   localparam logic [31:0] HASH_PZ  = 32'd83492791;
   localparam logic [31:0] CELL_SAT = 32'h7FFF_FFFF;

   localparam logic [2:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [2:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [2:0] CSR_INV_CELL = 3'd3;
   localparam logic [2:0] CSR_TBL_SIZE = 3'd4;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam int SQRT_STEPS = 24;  // 48-bit radicand, one result bit per cycle
   localparam int MOD_BITS   = 4;   // remainder bits per cycle
   localparam int MOD_STEPS  = 32 / MOD_BITS;
   localparam int BND_COUNT  = 6;   // min and max on three axes

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_SQRT  = 10'b00_0000_0010,
      ST_BMUL  = 10'b00_0000_0100,
      ST_BADD  = 10'b00_0000_1000,
      ST_CHECK = 10'b00_0001_0000,
      ST_HMUL  = 10'b00_0010_0000,
      ST_HSTO  = 10'b00_0100_0000,
      ST_MINIT = 10'b00_1000_0000,
      ST_MSTEP = 10'b01_0000_0000,
      ST_EMIT  = 10'b10_0000_0000
   } state_type;

   typedef struct packed {
      logic       load;
      logic       sqrt_step;
      logic       bnd_mul;
      logic       bnd_add;
      logic [2:0] sel;       // bound number: axis in [2:1], max in [0]
      logic       hmul;
      logic       hstore;
      logic [1:0] axis;
      logic       mod_init;
      logic       mod_step;
      logic [2:0] corner;    // z,y,x offsets
      logic       emit;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic       skip;
      logic       empty;
      logic [2:0] two;       // axis spans two cells
      logic       out_busy;
   } sts_type;

endpackage

FILE: design/spatial_hash_cell_binning_unit.sv
// ---------------------------------------------------------------------------
// spatial_hash_cell_binning_unit: bins hit points into spatial hash buckets
// Emits one bucket per grid cell overlapped by the point's radius box.
// ---------------------------------------------------------------------------
//  channel  handshake             payload
//  req      req_valid/req_ready   point_index, is_surface, pos_x/y/z, radius_squared
//  rsp      rsp_valid/rsp_ready   bucket, entry_index, last
//  csr      csr_wr_en             csr_index, csr_wdata
//
// A skipped point is taken in idle with no further steps. A binned point runs the
// square root (one bit per cycle), six bounds on the shared multiplier, an empty
// check, three hash products, then per bucket a modulo (4 bits per cycle) and an emit.
// Reset is synchronous and clears the sequencer, the result flag and the
// grid settings.
// A held result stalls the sequencer at its next emit; the next point is
// taken while the last result still waits.
module spatial_hash_cell_binning_unit import shbin_pkg::*; #(
   parameter int MAX_POINTS  = DEF_MAX_POINTS,
   parameter int MAX_BUCKETS = DEF_MAX_BUCKETS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_point_index,
   input  logic        req_is_surface,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [31:0] req_radius_squared,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [19:0] rsp_bucket,
   output logic [15:0] rsp_entry_index,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   shbin_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   shbin_dp #(
      .MAX_POINTS  (MAX_POINTS),
      .MAX_BUCKETS (MAX_BUCKETS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_point_index    (req_point_index),
      .req_is_surface     (req_is_surface),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_pos_z          (req_pos_z),
      .req_radius_squared (req_radius_squared),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_bucket         (rsp_bucket),
      .rsp_entry_index    (rsp_entry_index),
      .rsp_last           (rsp_last)
   );

   // never overwrite a result that has not been transferred
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !sts.out_busy) else $error("result overwritten");

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.sqrt_step, cmd.bnd_mul, cmd.bnd_add, cmd.hmul,
                cmd.hstore, cmd.mod_init, cmd.mod_step, cmd.emit}))
      else $error("conflicting datapath commands");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && cmd.last |=> req_ready && rsp_valid && rsp_last)
      else $error("not ready after final result");

endmodule

FILE: design/shbin_ctrl.sv
// ---------------------------------------------------------------------------
// shbin_ctrl: sequencer for the spatial hash binning unit
// Steps square root, bound scaling, hash products, modulo and result issue.
// ---------------------------------------------------------------------------
module shbin_ctrl import shbin_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type  state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [2:0] cell_ff, cell_in;
   logic [2:0] cell_next;
   logic       cell_last;

   // z outermost, x innermost
   always_comb begin
      cell_next = 3'b000;
      cell_last = 1'b0;
      if (sts.two[0] && !cell_ff[0]) begin
         cell_next = {cell_ff[2:1], 1'b1};
      end else if (sts.two[1] && !cell_ff[1]) begin
         cell_next = {cell_ff[2], 2'b10};
      end else if (sts.two[2] && !cell_ff[2]) begin
         cell_next = 3'b100;
      end else begin
         cell_last = 1'b1;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cell_in   = cell_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               if (!sts.skip) state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(SQRT_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_BMUL;
            end
         end
         ST_BMUL: begin
            cmd.bnd_mul = 1'b1;
            cmd.sel     = cnt_ff[2:0];
            state_in    = ST_BADD;
         end
         ST_BADD: begin
            cmd.bnd_add = 1'b1;
            cmd.sel     = cnt_ff[2:0];
            if (cnt_ff == 5'(BND_COUNT - 1)) begin
               cnt_in   = '0;
               state_in = ST_CHECK;
            end else begin
               cnt_in   = cnt_ff + 5'd1;
               state_in = ST_BMUL;
            end
         end
         ST_CHECK: begin
            state_in = sts.empty ? ST_IDLE : ST_HMUL;
         end
         ST_HMUL: begin
            cmd.hmul = 1'b1;
            cmd.axis = cnt_ff[1:0];
            state_in = ST_HSTO;
         end
         ST_HSTO: begin
            cmd.hstore = 1'b1;
            cmd.axis   = cnt_ff[1:0];
            if (cnt_ff[1:0] == AXIS_Z) begin
               cnt_in   = '0;
               cell_in  = '0;
               state_in = ST_MINIT;
            end else begin
               cnt_in   = cnt_ff + 5'd1;
               state_in = ST_HMUL;
            end
         end
         ST_MINIT: begin
            cmd.mod_init = 1'b1;
            cmd.corner   = cell_ff;
            cnt_in       = '0;
            state_in     = ST_MSTEP;
         end
         ST_MSTEP: begin
            cmd.mod_step = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(MOD_STEPS - 1)) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!sts.out_busy) begin
               cmd.emit = 1'b1;
               cmd.last = cell_last;
               if (cell_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cell_in  = cell_next;
                  state_in = ST_MINIT;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         cell_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         cell_ff  <= cell_in;
      end
   end

endmodule

FILE: design/shbin_dp.sv
// ---------------------------------------------------------------------------
// shbin_dp: datapath for the spatial hash binning unit
// Config registers, bit-serial square root, shared multiplier, modulo, output.
// ---------------------------------------------------------------------------
module shbin_dp import shbin_pkg::*; #(
   parameter int MAX_POINTS  = DEF_MAX_POINTS,
   parameter int MAX_BUCKETS = DEF_MAX_BUCKETS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] req_point_index,
   input  logic        req_is_surface,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [31:0] req_radius_squared,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [19:0] rsp_bucket,
   output logic [15:0] rsp_entry_index,
   output logic        rsp_last
);

   localparam int SW = $clog2(MAX_BUCKETS + 1);

   logic [31:0] org_x_ff, org_y_ff, org_z_ff, ics_ff;
   logic [20:0] tsz_ff;

   logic [15:0] idx_ff;
   logic [31:0] px_ff, py_ff, pz_ff;
   logic [47:0] srem_ff, sres_ff, sbit_ff;
   logic [48:0] ssum;
   logic        sge;

   logic [31:0] pos_sel, org_sel;
   logic [34:0] p35, o35, r35, d35;
   logic [33:0] mag;
   logic [63:0] prod_ff;
   logic [1:0]  mhi_ff;
   logic [34:0] csum;
   logic [31:0] csat;
   logic [31:0] cmin_ff [3];
   logic [31:0] cmax_ff [3];
   logic [31:0] mul_a, mul_b;
   logic [31:0] hp_ff [3];

   logic [31:0] ts32, size32;
   logic [SW-1:0] size;
   logic [31:0] hq_ff, hq_in;
   logic [SW-1:0] mrem_ff, mrem_in;
   logic [SW:0]   mshift;
   logic [31:0] hx, hy, hz;
   logic [31:0] bucket32;

   logic        ov_ff;
   logic [19:0] obkt_ff;
   logic [15:0] oidx_ff;
   logic        olast_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff <= '0;
         org_y_ff <= '0;
         org_z_ff <= '0;
         ics_ff   <= 32'd65536;
         tsz_ff   <= 21'd65536;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ORIGIN_X: org_x_ff <= csr_wdata;
            CSR_ORIGIN_Y: org_y_ff <= csr_wdata;
            CSR_ORIGIN_Z: org_z_ff <= csr_wdata;
            CSR_INV_CELL: ics_ff   <= csr_wdata;
            CSR_TBL_SIZE: tsz_ff   <= csr_wdata[20:0];
            default: ;
         endcase
      end
   end

   // square root, one result bit per cycle
   assign ssum = {1'b0, sres_ff} + {1'b0, sbit_ff};
   assign sge  = {1'b0, srem_ff} >= ssum;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff  <= req_point_index;
         px_ff   <= req_pos_x;
         py_ff   <= req_pos_y;
         pz_ff   <= req_pos_z;
         srem_ff <= {req_radius_squared, 16'b0};
         sres_ff <= '0;
         sbit_ff <= 48'h4000_0000_0000;
      end else if (cmd.sqrt_step) begin
         if (sge) begin
            srem_ff <= srem_ff - ssum[47:0];
            sres_ff <= (sres_ff >> 1) + sbit_ff;
         end else begin
            sres_ff <= sres_ff >> 1;
         end
         sbit_ff <= sbit_ff >> 2;
      end
   end

   // bound: |pos -/+ r - origin| scaled by the inverse cell size
   always_comb begin
      case (cmd.sel[2:1])
         AXIS_X: begin pos_sel = px_ff; org_sel = org_x_ff; end
         AXIS_Y: begin pos_sel = py_ff; org_sel = org_y_ff; end
         default: begin pos_sel = pz_ff; org_sel = org_z_ff; end
      endcase
      p35 = {{3{pos_sel[31]}}, pos_sel};
      o35 = {{3{org_sel[31]}}, org_sel};
      r35 = {11'b0, sres_ff[23:0]};
      d35 = cmd.sel[0] ? (p35 + r35 - o35) : (p35 - r35 - o35);
      mag = d35[34] ? 34'(-d35) : d35[33:0];
   end

   always_comb begin
      if (cmd.hmul) begin
         mul_a = cmin_ff[cmd.axis];
         case (cmd.axis)
            AXIS_X:  mul_b = HASH_PX;
            AXIS_Y:  mul_b = HASH_PY;
            default: mul_b = HASH_PZ;
         endcase
      end else begin
         mul_a = mag[31:0];
         mul_b = ics_ff;
      end
   end

   assign csum = 35'(mhi_ff) * 35'(ics_ff) + 35'(prod_ff[63:32]);
   assign csat = (csum > 35'(CELL_SAT)) ? CELL_SAT : csum[31:0];

   always_ff @(posedge clock) begin
      if (cmd.bnd_mul || cmd.hmul) begin
         prod_ff <= 64'(mul_a) * 64'(mul_b);
         mhi_ff  <= mag[33:32];
      end
      if (cmd.bnd_add) begin
         if (cmd.sel[0]) cmax_ff[cmd.sel[2:1]] <= csat;
         else            cmin_ff[cmd.sel[2:1]] <= csat;
      end
      if (cmd.hstore) hp_ff[cmd.axis] <= prod_ff[31:0];
   end

   always_comb begin
      sts.skip     = !req_is_surface || (32'(req_point_index) >= 32'(MAX_POINTS));
      sts.out_busy = ov_ff;
      sts.empty    = 1'b0;
      for (int a = 0; a < 3; a++) begin
         sts.two[a] = cmax_ff[a] > cmin_ff[a];
         if (cmin_ff[a] > cmax_ff[a]) sts.empty = 1'b1;
      end
   end

   // modulo by the clamped table size, restoring, MOD_BITS per cycle
   assign ts32   = 32'(tsz_ff);
   assign size32 = (ts32 == 32'd0) ? 32'd1 :
                   (ts32 > 32'(MAX_BUCKETS)) ? 32'(MAX_BUCKETS) : ts32;
   assign size   = size32[SW-1:0];

   // the upper cell's product is the lower one's plus the prime
   assign hx = cmd.corner[0] ? hp_ff[AXIS_X] + HASH_PX : hp_ff[AXIS_X];
   assign hy = cmd.corner[1] ? hp_ff[AXIS_Y] + HASH_PY : hp_ff[AXIS_Y];
   assign hz = cmd.corner[2] ? hp_ff[AXIS_Z] + HASH_PZ : hp_ff[AXIS_Z];

   always_comb begin
      hq_in   = hq_ff;
      mrem_in = mrem_ff;
      mshift  = '0;
      for (int i = 0; i < MOD_BITS; i++) begin
         mshift = {mrem_in, hq_in[31]};
         hq_in  = hq_in << 1;
         if (mshift >= {1'b0, size}) mshift = mshift - {1'b0, size};
         mrem_in = mshift[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mod_init) begin
         hq_ff   <= hx ^ hy ^ hz;
         mrem_ff <= '0;
      end else if (cmd.mod_step) begin
         hq_ff   <= hq_in;
         mrem_ff <= mrem_in;
      end
   end

   // result register
   assign bucket32 = 32'(mrem_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (cmd.emit) begin
         ov_ff <= 1'b1;
      end else if (rsp_ready) begin
         ov_ff <= 1'b0;
      end
      if (cmd.emit) begin
         obkt_ff  <= bucket32[19:0];
         oidx_ff  <= idx_ff;
         olast_ff <= cmd.last;
      end
   end

   assign rsp_valid       = ov_ff;
   assign rsp_bucket      = obkt_ff;
   assign rsp_entry_index = oidx_ff;
   assign rsp_last        = olast_ff;

endmodule
